// ===== design/hseq_pkg.sv =====
// shared types, codes and constants of the link bring-up sequencer
package hseq_pkg;

    // longest frame counted, longer frames are clipped to this length
    localparam int unsigned MAX_FRAME_BYTES = 160;
    localparam logic [7:0]  MIN_FRAME_BYTES = 8'd3;
    localparam logic [7:0]  PREVIEW_MIN_BYTES = 8'd9;

    localparam int unsigned CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] OFFLINE_LIMIT_RST = 12'd1500;
    localparam logic [CNT_W-1:0] RETRY_PERIOD_RST  = 12'd3000;
    localparam logic [CNT_W-1:0] CHAL_WAIT_RST     = 12'd100;

    // register word indexes on the configuration port
    localparam logic [1:0] REG_OFFLINE_LIMIT = 2'd0;
    localparam logic [1:0] REG_RETRY_PERIOD  = 2'd1;
    localparam logic [1:0] REG_CHAL_WAIT     = 2'd2;

    // request kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // frame type, object and sub codes
    localparam logic [7:0] TYPE_FB = 8'hFB;
    localparam logic [7:0] TYPE_AF = 8'hAF;
    localparam logic [7:0] TYPE_F9 = 8'hF9;
    localparam logic [7:0] TYPE_FC = 8'hFC;
    localparam logic [7:0] TYPE_F2 = 8'hF2;
    localparam logic [7:0] TYPE_F5 = 8'hF5;
    localparam logic [7:0] TYPE_FA = 8'hFA;
    localparam logic [7:0] TYPE_FD = 8'hFD;
    localparam logic [7:0] OBJ_ACK0  = 8'h2A;
    localparam logic [7:0] OBJ_FINAL = 8'h2B;
    localparam logic [7:0] OBJ_33    = 8'h33;
    localparam logic [7:0] SUB_RESYNC = 8'h02;
    localparam logic [7:0] SUB_SNAP   = 8'h04;
    localparam logic [7:0] SUB_SLOT2  = 8'h07;
    localparam logic [7:0] SUB_TONE   = 8'h09;

    // packet codes to send
    localparam logic [3:0] SEND_NONE  = 4'd0;
    localparam logic [3:0] SEND_PKT0  = 4'd1;
    localparam logic [3:0] SEND_PKT1  = 4'd2;
    localparam logic [3:0] SEND_PKT2  = 4'd3;
    localparam logic [3:0] SEND_PKT3  = 4'd4;
    localparam logic [3:0] SEND_PKT4  = 4'd5;
    localparam logic [3:0] SEND_PKT5  = 4'd6;
    localparam logic [3:0] SEND_PKT6  = 4'd7;
    localparam logic [3:0] SEND_PKT7  = 4'd8;
    localparam logic [3:0] SEND_REPLY = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_ACK0  = 4'd1,
        ST_BLOB  = 4'd2,
        ST_SNAP  = 4'd3,
        ST_FC    = 4'd4,
        ST_F2    = 4'd5,
        ST_SLOT2 = 4'd6,
        ST_TONE  = 4'd7,
        ST_FINAL = 4'd8,
        ST_CHAL  = 4'd9,
        ST_READY = 4'd10
    } hseq_state_t;

    typedef struct packed {
        logic [CNT_W-1:0] offline_limit_ms;
        logic [CNT_W-1:0] retry_period_ms;
        logic [CNT_W-1:0] challenge_wait_ms;
    } hseq_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_type;
        logic [7:0] object_id;
        logic [7:0] sub_id;
        logic [7:0] frame_length;
    } hseq_item_t;

    typedef struct packed {
        logic [3:0]  send_packet;
        logic        link_ready;
        logic        seq_locked;
        hseq_state_t seq_state;
    } hseq_result_t;

endpackage

// ===== design/hseq_cfg.sv =====
// configuration registers behind the apb port
module hseq_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output hseq_pkg::hseq_cfg_t cfg
);

    hseq_pkg::hseq_cfg_t cfg_reg;
    logic                wr_en;
    logic [1:0]          word_idx;

    assign pready   = 1'b1;
    assign word_idx = paddr[3:2];
    assign wr_en    = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offline_limit_ms  <= hseq_pkg::OFFLINE_LIMIT_RST;
            cfg_reg.retry_period_ms   <= hseq_pkg::RETRY_PERIOD_RST;
            cfg_reg.challenge_wait_ms <= hseq_pkg::CHAL_WAIT_RST;
        end
        else if (wr_en)
        begin
            unique case (word_idx)
                hseq_pkg::REG_OFFLINE_LIMIT: cfg_reg.offline_limit_ms  <= pwdata[11:0];
                hseq_pkg::REG_RETRY_PERIOD:  cfg_reg.retry_period_ms   <= pwdata[11:0];
                hseq_pkg::REG_CHAL_WAIT:     cfg_reg.challenge_wait_ms <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (word_idx)
            hseq_pkg::REG_OFFLINE_LIMIT: prdata = {20'd0, cfg_reg.offline_limit_ms};
            hseq_pkg::REG_RETRY_PERIOD:  prdata = {20'd0, cfg_reg.retry_period_ms};
            hseq_pkg::REG_CHAL_WAIT:     prdata = {20'd0, cfg_reg.challenge_wait_ms};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/hseq_core.sv =====
// sequencer state, timers and the per-request update
module hseq_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  hseq_pkg::hseq_item_t   item,
    input  hseq_pkg::hseq_cfg_t    cfg,
    output hseq_pkg::hseq_result_t result
);

    hseq_pkg::hseq_state_t state_reg, state_next;
    logic ready_reg, ready_next;
    logic locked_reg, locked_next;
    logic prog_reg, prog_next;
    logic online_reg, online_next;
    logic [hseq_pkg::CNT_W-1:0] start_cnt_reg, start_cnt_next;
    logic [hseq_pkg::CNT_W-1:0] retry_cnt_reg, retry_cnt_next;
    logic [hseq_pkg::CNT_W-1:0] ack_cnt_reg, ack_cnt_next;

    logic [hseq_pkg::CNT_W-1:0] start_inc, retry_inc, ack_inc;
    logic [7:0] len_eff;
    logic [3:0] send;
    logic       do_restart;
    logic       is_preview;
    logic       is_resync;

    assign start_inc = (start_cnt_reg == hseq_pkg::CNT_MAX) ? start_cnt_reg
                                                            : start_cnt_reg + 1'b1;
    assign retry_inc = (retry_cnt_reg == hseq_pkg::CNT_MAX) ? retry_cnt_reg
                                                            : retry_cnt_reg + 1'b1;
    assign ack_inc   = (ack_cnt_reg == hseq_pkg::CNT_MAX) ? ack_cnt_reg
                                                          : ack_cnt_reg + 1'b1;

    assign len_eff = (item.frame_length > 8'(hseq_pkg::MAX_FRAME_BYTES))
                     ? 8'(hseq_pkg::MAX_FRAME_BYTES) : item.frame_length;

    // colour preview marks online but never moves the sequence
    assign is_preview = (item.frame_type == hseq_pkg::TYPE_FA)
                     && (item.object_id == hseq_pkg::OBJ_33)
                     && (len_eff >= hseq_pkg::PREVIEW_MIN_BYTES);
    assign is_resync  = (item.frame_type == hseq_pkg::TYPE_FD)
                     && (item.object_id == hseq_pkg::OBJ_33)
                     && (item.sub_id == hseq_pkg::SUB_RESYNC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hseq_pkg::ST_IDLE;
            ready_reg     <= 1'b0;
            locked_reg    <= 1'b0;
            prog_reg      <= 1'b0;
            online_reg    <= 1'b0;
            start_cnt_reg <= '0;
            retry_cnt_reg <= '0;
            ack_cnt_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            locked_reg    <= locked_next;
            prog_reg      <= prog_next;
            online_reg    <= online_next;
            start_cnt_reg <= start_cnt_next;
            retry_cnt_reg <= retry_cnt_next;
            ack_cnt_reg   <= ack_cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        locked_next    = locked_reg;
        prog_next      = prog_reg;
        online_next    = online_reg;
        start_cnt_next = start_cnt_reg;
        retry_cnt_next = retry_cnt_reg;
        ack_cnt_next   = ack_cnt_reg;
        send           = hseq_pkg::SEND_NONE;
        do_restart     = 1'b0;

        unique case (item.kind)
            hseq_pkg::KIND_FRAME:
            begin
                if (len_eff >= hseq_pkg::MIN_FRAME_BYTES)
                begin
                    if (item.frame_type != hseq_pkg::TYPE_FD)
                        online_next = 1'b1;
                    if (is_preview)
                        send = hseq_pkg::SEND_NONE;
                    else if (is_resync)
                        do_restart = 1'b1;
                    else if (!locked_reg)
                    begin
                        unique case (state_reg)
                            hseq_pkg::ST_ACK0:
                                if (item.frame_type == hseq_pkg::TYPE_FB
                                    && item.object_id == hseq_pkg::OBJ_ACK0)
                                begin
                                    send = hseq_pkg::SEND_PKT1;
                                    state_next = hseq_pkg::ST_BLOB;
                                end
                            hseq_pkg::ST_BLOB:
                                if (item.frame_type == hseq_pkg::TYPE_AF)
                                begin
                                    send = hseq_pkg::SEND_PKT2;
                                    state_next = hseq_pkg::ST_SNAP;
                                end
                            hseq_pkg::ST_SNAP:
                                if (item.frame_type == hseq_pkg::TYPE_F9
                                    && item.sub_id == hseq_pkg::SUB_SNAP)
                                begin
                                    send = hseq_pkg::SEND_PKT3;
                                    state_next = hseq_pkg::ST_FC;
                                end
                            hseq_pkg::ST_FC:
                                if (item.frame_type == hseq_pkg::TYPE_FC)
                                begin
                                    send = hseq_pkg::SEND_PKT4;
                                    state_next = hseq_pkg::ST_F2;
                                end
                            hseq_pkg::ST_F2:
                                if (item.frame_type == hseq_pkg::TYPE_F2)
                                begin
                                    send = hseq_pkg::SEND_PKT5;
                                    state_next = hseq_pkg::ST_SLOT2;
                                end
                            hseq_pkg::ST_SLOT2:
                                if (item.frame_type == hseq_pkg::TYPE_F9
                                    && item.sub_id == hseq_pkg::SUB_SLOT2)
                                begin
                                    send = hseq_pkg::SEND_PKT6;
                                    state_next = hseq_pkg::ST_TONE;
                                end
                            hseq_pkg::ST_TONE:
                                if (item.frame_type == hseq_pkg::TYPE_F5
                                    && item.sub_id == hseq_pkg::SUB_TONE)
                                begin
                                    send = hseq_pkg::SEND_PKT7;
                                    state_next = hseq_pkg::ST_FINAL;
                                end
                            hseq_pkg::ST_FINAL:
                                if (item.frame_type == hseq_pkg::TYPE_FB
                                    && item.object_id == hseq_pkg::OBJ_FINAL)
                                begin
                                    ready_next   = 1'b1;
                                    prog_next    = 1'b0;
                                    ack_cnt_next = '0;
                                    state_next   = hseq_pkg::ST_CHAL;
                                end
                            hseq_pkg::ST_CHAL:
                            begin
                                if (item.frame_type == hseq_pkg::TYPE_FD
                                    && item.object_id == hseq_pkg::OBJ_33)
                                    send = hseq_pkg::SEND_REPLY;
                                // a reply, or a late frame past the window, ends the wait
                                if (send == hseq_pkg::SEND_REPLY
                                    || ack_cnt_reg > cfg.challenge_wait_ms)
                                begin
                                    locked_next = 1'b1;
                                    prog_next   = 1'b0;
                                    state_next  = hseq_pkg::ST_READY;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            hseq_pkg::KIND_TICK:
            begin
                start_cnt_next = start_inc;
                retry_cnt_next = retry_inc;
                ack_cnt_next   = ack_inc;
                // offline back-off
                if (prog_reg && !online_reg && start_inc > cfg.offline_limit_ms)
                begin
                    prog_next   = 1'b0;
                    locked_next = 1'b1;
                    state_next  = hseq_pkg::ST_IDLE;
                end
                if (!ready_reg && !online_reg && retry_inc > cfg.retry_period_ms)
                begin
                    do_restart     = 1'b1;
                    retry_cnt_next = '0;
                end
            end
            hseq_pkg::KIND_START:
                do_restart = 1'b1;
            default: ;
        endcase

        if (do_restart)
        begin
            online_next    = 1'b0;
            start_cnt_next = '0;
            ready_next     = 1'b0;
            locked_next    = 1'b0;
            prog_next      = 1'b1;
            state_next     = hseq_pkg::ST_ACK0;
            send           = hseq_pkg::SEND_PKT0;
        end

        result.send_packet = send;
        result.link_ready  = ready_next;
        result.seq_locked  = locked_next;
        result.seq_state   = state_next;
    end

endmodule

// ===== design/handshake_sequencer.sv =====
// link bring-up sequencer top level: request and result registers around the core
// an accepted request waits in the request register, its result in the result register
// throughput: one request per cycle if m_tready holds; the update is a single hseq_core pass
// the result register and the request register let both sides stall independently
// reset: rst_n asynchronous, clears both valid flags, the sequencer state and the timers,
// and loads the configuration registers with their defaults
module handshake_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // frame_type, object_id, sub_id, frame_length
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // send_packet, link_ready, seq_locked, seq_state, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hseq_pkg::hseq_cfg_t    cfg;
    hseq_pkg::hseq_item_t   item_reg;
    hseq_pkg::hseq_result_t result;
    hseq_pkg::hseq_result_t out_reg;
    logic                   item_valid_reg;
    logic                   out_valid_reg;
    logic                   advance;
    logic                   s_fire;

    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    hseq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hseq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_fire)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.kind         <= s_tuser;
            item_reg.frame_type   <= s_tdata[7:0];
            item_reg.object_id    <= s_tdata[15:8];
            item_reg.sub_id       <= s_tdata[23:16];
            item_reg.frame_length <= s_tdata[31:24];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.seq_state, out_reg.seq_locked,
                       out_reg.link_ready, out_reg.send_packet};

    // ready state is only reached through the challenge, with the link up and locked
    a_ready_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.seq_state == hseq_pkg::ST_READY
        |-> out_reg.link_ready && out_reg.seq_locked)
        else $error("ready state without ready and locked flags");

    // the challenge reply always ends in the ready state
    a_reply_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.send_packet == hseq_pkg::SEND_REPLY
        |-> out_reg.seq_state == hseq_pkg::ST_READY)
        else $error("challenge reply outside the ready state");

    // a restart packet comes with a fresh, unlocked sequence
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.send_packet == hseq_pkg::SEND_PKT0
        |-> out_reg.seq_state == hseq_pkg::ST_ACK0 && !out_reg.link_ready
            && !out_reg.seq_locked)
        else $error("restart packet with stale sequence state");

    // every request that leaves the input register produces a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("request processed without a result");

endmodule

// ===== verif/hseq_checker.sv =====
// request/result checker for the link bring-up sequencer: predicts and compares every result
`timescale 1ns / 1ps

module hseq_checker
    import hseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // frame_type, object_id, sub_id, frame_length
    input  logic [1:0]  s_tuser,  // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,  // send_packet, link_ready, seq_locked, seq_state, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_count,
    output int          checked_count,
    output int          reply_count
);

    logic [CNT_W-1:0] lim_offline;
    logic [CNT_W-1:0] lim_retry;
    logic [CNT_W-1:0] lim_chal;

    hseq_state_t      cur_state;
    logic             ready_q;
    logic             locked_q;
    logic             busy_q;
    logic             online_q;
    logic [CNT_W-1:0] ms_start;
    logic [CNT_W-1:0] ms_retry;
    logic [CNT_W-1:0] ms_ack;

    hseq_result_t     expected_results[$];

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    task automatic restart_link(output logic [3:0] pkt);
        online_q  = 1'b0;
        ms_start  = '0;
        ready_q   = 1'b0;
        locked_q  = 1'b0;
        busy_q    = 1'b1;
        cur_state = ST_ACK0;
        pkt       = SEND_PKT0;
    endtask

    task automatic enter_ready();
        locked_q  = 1'b1;
        busy_q    = 1'b0;
        cur_state = ST_READY;
    endtask

    // one step of the wait-state walk for a frame that reached the sequencer
    task automatic walk_handshake(input logic [7:0] ft, input logic [7:0] ob,
                                  input logic [7:0] sb, inout logic [3:0] pkt);
        case (cur_state)
            ST_ACK0:
                if (ft == TYPE_FB && ob == OBJ_ACK0)
                begin
                    pkt = SEND_PKT1;
                    cur_state = ST_BLOB;
                end
            ST_BLOB:
                if (ft == TYPE_AF)
                begin
                    pkt = SEND_PKT2;
                    cur_state = ST_SNAP;
                end
            ST_SNAP:
                if (ft == TYPE_F9 && sb == SUB_SNAP)
                begin
                    pkt = SEND_PKT3;
                    cur_state = ST_FC;
                end
            ST_FC:
                if (ft == TYPE_FC)
                begin
                    pkt = SEND_PKT4;
                    cur_state = ST_F2;
                end
            ST_F2:
                if (ft == TYPE_F2)
                begin
                    pkt = SEND_PKT5;
                    cur_state = ST_SLOT2;
                end
            ST_SLOT2:
                if (ft == TYPE_F9 && sb == SUB_SLOT2)
                begin
                    pkt = SEND_PKT6;
                    cur_state = ST_TONE;
                end
            ST_TONE:
                if (ft == TYPE_F5 && sb == SUB_TONE)
                begin
                    pkt = SEND_PKT7;
                    cur_state = ST_FINAL;
                end
            ST_FINAL:
                if (ft == TYPE_FB && ob == OBJ_FINAL)
                begin
                    ready_q   = 1'b1;
                    busy_q    = 1'b0;
                    ms_ack    = '0;
                    cur_state = ST_CHAL;
                end
            ST_CHAL:
                if (ft == TYPE_FD && ob == OBJ_33)
                begin
                    pkt = SEND_REPLY;
                    enter_ready();
                end
                else if (ms_ack > lim_chal)
                begin
                    enter_ready();
                end
            default:
                ;
        endcase
    endtask

    task automatic predict_link(input logic [1:0] kind, input logic [31:0] data,
                                output hseq_result_t res);
        logic [7:0] ft;
        logic [7:0] ob;
        logic [7:0] sb;
        logic [7:0] len;
        logic [3:0] pkt;
        ft  = data[7:0];
        ob  = data[15:8];
        sb  = data[23:16];
        len = data[31:24];
        pkt = SEND_NONE;
        case (kind)
            KIND_FRAME:
            begin
                if (len > MAX_FRAME_BYTES)
                    len = 8'(MAX_FRAME_BYTES);
                if (len >= MIN_FRAME_BYTES)
                begin
                    if (ft != TYPE_FD)
                        online_q = 1'b1;
                    // colour preview only marks the partner online
                    if (ft == TYPE_FA && ob == OBJ_33 && len >= PREVIEW_MIN_BYTES)
                        pkt = SEND_NONE;
                    else if (ft == TYPE_FD && ob == OBJ_33 && sb == SUB_RESYNC)
                        restart_link(pkt);
                    else if (!locked_q)
                        walk_handshake(ft, ob, sb, pkt);
                end
            end
            KIND_TICK:
            begin
                ms_start = sat_inc(ms_start);
                ms_retry = sat_inc(ms_retry);
                ms_ack   = sat_inc(ms_ack);
                if (busy_q && !online_q && ms_start > lim_offline)
                begin
                    busy_q    = 1'b0;
                    locked_q  = 1'b1;
                    cur_state = ST_IDLE;
                end
                if (!ready_q && !online_q && ms_retry > lim_retry)
                begin
                    restart_link(pkt);
                    ms_retry = '0;
                end
            end
            KIND_START:
                restart_link(pkt);
            default:
                ;
        endcase
        res.send_packet = pkt;
        res.link_ready  = ready_q;
        res.seq_locked  = locked_q;
        res.seq_state   = cur_state;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hseq_result_t want;
        if (!rst_n)
        begin
            lim_offline = OFFLINE_LIMIT_RST;
            lim_retry   = RETRY_PERIOD_RST;
            lim_chal    = CHAL_WAIT_RST;
            cur_state   = ST_IDLE;
            ready_q     = 1'b0;
            locked_q    = 1'b0;
            busy_q      = 1'b0;
            online_q    = 1'b0;
            ms_start    = '0;
            ms_retry    = '0;
            ms_ack      = '0;
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_OFFLINE_LIMIT: lim_offline = pwdata[CNT_W-1:0];
                    REG_RETRY_PERIOD:  lim_retry   = pwdata[CNT_W-1:0];
                    REG_CHAL_WAIT:     lim_chal    = pwdata[CNT_W-1:0];
                    default:           ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                predict_link(s_tuser, s_tdata, want);
                expected_results.push_back(want);
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result 0x%h arrived with no request outstanding", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (m_tdata[3:0] == SEND_REPLY)
                        reply_count++;
                    if (m_tdata[3:0] !== want.send_packet)
                    begin
                        $error("send_packet: expected %0d, actual %0d",
                               want.send_packet, m_tdata[3:0]);
                        error_count++;
                    end
                    if (m_tdata[4] !== want.link_ready)
                    begin
                        $error("link_ready: expected %0d, actual %0d",
                               want.link_ready, m_tdata[4]);
                        error_count++;
                    end
                    if (m_tdata[5] !== want.seq_locked)
                    begin
                        $error("seq_locked: expected %0d, actual %0d",
                               want.seq_locked, m_tdata[5]);
                        error_count++;
                    end
                    if (m_tdata[9:6] !== want.seq_state)
                    begin
                        $error("seq_state: expected %0d, actual %0d",
                               want.seq_state, m_tdata[9:6]);
                        error_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        checked_count = 0;
        reply_count   = 0;
    end

endmodule

// ===== verif/tb_handshake_sequencer.sv =====
// testbench top for the link bring-up sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_handshake_sequencer;
    import hseq_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;  // kind code the block must ignore
    localparam logic [1:0] REG_SPARE   = 2'd3;  // unmapped register slot
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int SOAK_TICKS    = 40;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // frame_type, object_id, sub_id, frame_length
    logic [1:0]  s_tuser;  // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // send_packet, link_ready, seq_locked, seq_state, zero pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int error_count;
    int pending_count;
    int checked_count;
    int reply_count;
    int sent_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b1;
    bit hold_pending = 1'b0;

    handshake_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hseq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .reply_count   (reply_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !gaps_on || ($urandom_range(99) >= 11);
        end
    end

    task automatic drive_request(input logic [1:0] kind, input logic [7:0] ft,
                                 input logic [7:0] ob, input logic [7:0] sb,
                                 input logic [7:0] len);
        if (gaps_on && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {len, sb, ob, ft};
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    task automatic send_frame(input logic [7:0] ft, input logic [7:0] ob,
                              input logic [7:0] sb, input logic [7:0] len);
        drive_request(KIND_FRAME, ft, ob, sb, len);
    endtask

    task automatic send_tick();
        drive_request(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_start();
        drive_request(KIND_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] rand_len();
        if ($urandom_range(19) == 0)
            return 8'($urandom_range(0, 2));
        return 8'($urandom_range(3, 255));
    endfunction

    task automatic send_noise();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (r < 75)
            send_tick();
        else if (r < 85)
            send_start();
        else if (r < 93)
            send_frame(TYPE_FD, OBJ_33, 8'($urandom_range(0, 3)), rand_len());
        else
            drive_request(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
    endtask

    task automatic send_handshake_frame(input int step);
        case (step)
            0: send_frame(TYPE_FB, OBJ_ACK0, 8'($urandom), rand_len());
            1: send_frame(TYPE_AF, 8'($urandom), 8'($urandom), rand_len());
            2: send_frame(TYPE_F9, 8'($urandom), SUB_SNAP, rand_len());
            3: send_frame(TYPE_FC, 8'($urandom), 8'($urandom), rand_len());
            4: send_frame(TYPE_F2, 8'($urandom), 8'($urandom), rand_len());
            5: send_frame(TYPE_F9, 8'($urandom), SUB_SLOT2, rand_len());
            6: send_frame(TYPE_F5, 8'($urandom), SUB_TONE, rand_len());
            default: send_frame(TYPE_FB, OBJ_FINAL, 8'($urandom), rand_len());
        endcase
    endtask

    // one bring-up attempt: an optional kick, up to eight handshake frames with noise, then an optional challenge
    task automatic run_bringup();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_start();
        else if (r < 85)
            send_frame(TYPE_FD, OBJ_33, SUB_RESYNC, 8'($urandom_range(3, 255)));
        for (int step = 0; step < 8; step++)
        begin
            while ($urandom_range(99) < 12)
                send_noise();
            if ($urandom_range(99) >= 6)
                send_handshake_frame(step);
        end
        repeat ($urandom_range(0, 6)) send_tick();
        r = $urandom_range(99);
        if (r < 50)
            send_frame(TYPE_FD, OBJ_33,
                       ($urandom_range(9) == 0) ? SUB_RESYNC : 8'($urandom), rand_len());
        else if (r < 80)
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), rand_len());
        repeat ($urandom_range(0, 4)) send_tick();
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
            run_bringup();
    endtask

    // stop offering requests and wait for every result to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int offline, input int retry, input int chal);
        write_reg(REG_OFFLINE_LIMIT, 32'(offline));
        write_reg(REG_RETRY_PERIOD, 32'(retry));
        write_reg(REG_CHAL_WAIT, 32'(chal));
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_FRAME;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed walk at the reset limits
        drive_request(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_tick();
        send_frame(TYPE_FB, OBJ_ACK0, 8'h00, 8'd3);      // idle: online only
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'd0);           // too short
        send_frame(TYPE_FD, OBJ_33, SUB_RESYNC, 8'd2);   // too short even for resync
        send_start();
        send_frame(TYPE_FB, OBJ_ACK0, 8'h00, 8'd255);    // clipped length
        send_frame(TYPE_AF, 8'h00, 8'hFF, 8'd160);
        send_frame(TYPE_F9, 8'hFF, SUB_SNAP, 8'd3);
        send_frame(TYPE_FC, 8'h00, 8'h00, 8'd8);
        send_frame(TYPE_F2, 8'hFF, 8'hFF, 8'd161);
        send_frame(TYPE_FA, OBJ_33, SUB_SLOT2, 8'd9);    // colour preview
        send_frame(TYPE_FA, OBJ_33, SUB_SLOT2, 8'd8);    // too short for a preview
        send_frame(TYPE_F9, 8'h00, SUB_SLOT2, 8'd20);
        send_frame(TYPE_F5, 8'hFF, SUB_TONE, 8'd4);
        send_frame(TYPE_FB, OBJ_FINAL, 8'h00, 8'd12);
        send_frame(TYPE_FD, OBJ_33, 8'h00, 8'd6);        // challenge answered
        send_frame(TYPE_FB, OBJ_ACK0, 8'h00, 8'd6);      // locked in ready
        send_tick();
        send_frame(TYPE_FD, OBJ_33, SUB_RESYNC, 8'd3);
        send_frame(TYPE_FD, 8'h00, 8'h00, 8'd3);
        send_start();
        send_tick();
        settle();

        // short timers so back-off, retry and challenge expiry all happen
        set_limits(5, 12, 3);
        write_reg(REG_SPARE, 32'h0000_0123);
        write_reg(REG_CHAL_WAIT, 32'hFFFF_F002);         // only the low 12 bits count
        run_random(20);
        hold_pending = 1'b1;
        run_random(100);
        settle();

        // low extreme, with a long stretch of no idling on either side
        set_limits(1, 1, 1);
        gaps_on = 1'b0;
        run_random(100);
        gaps_on = 1'b1;
        settle();

        set_limits(0, 0, 0);
        run_random(70);
        settle();

        set_limits(4000, 4000, 4000);
        run_random(70);
        settle();

        // every limit at the counter maximum
        set_limits(4095, 4095, 4095);
        send_start();
        repeat (SOAK_TICKS) send_tick();
        settle();
        write_reg(REG_OFFLINE_LIMIT, 32'd4094);
        write_reg(REG_RETRY_PERIOD, 32'd4094);
        send_tick();
        run_random(30);
        settle();

        set_limits(8, 20, 6);
        run_random(60);
        settle();

        $display("sent %0d requests over seven timer settings, including a %0d-tick run",
                 sent_count, SOAK_TICKS);
        $display("checked %0d results, %0d of them challenge replies",
                 checked_count, reply_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
